### sv/sha256_pkg.sv
// SHA-256 package: payload structs, FSM state type, controller/datapath
// command and status structs, round constants. No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // word source for the block buffer
  typedef enum logic [2:0] {
    SRC_MSG,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO,
    SRC_PAD
  } src_t;

  typedef struct packed {
    logic       push;      // write one word to block buffer
    src_t       src;
    logic       load_vars; // a..h <= chaining value
    logic       round;     // one compression round
    logic       fold;      // chaining value += a..h
    logic       reinit;    // chaining value, counters back to initial
    logic       add_bytes; // byte_total += count of accepted item
  } cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic [5:0] round_idx;
  } status_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### sv/sha256_dp.sv
// SHA-256 datapath: block buffer / schedule window, round registers,
// chaining value, byte counter, padding word. Uses sha256_pkg.
`timescale 1ns / 1ps
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::cmd_t     cmd,
  input  sha256_pkg::in_item_t in_item,
  input  logic [2:0]           emit_idx,
  output sha256_pkg::status_t  status,
  output logic [31:0]          digest_word
);
  import sha256_pkg::*;

  logic [31:0] win_r [16];
  logic [31:0] v_r   [8];
  logic [31:0] h_r   [8];
  logic [60:0] total_r;
  logic [3:0]  fill_r;
  logic [5:0]  rnd_r;

  logic [2:0]  nb, add_n;
  logic [31:0] keep, msg_w, push_w, w, s0, s1, t1, t2, w15, w2;
  logic [63:0] bits;
  logic [3:0]  t4;

  always_comb begin
    nb = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
    // non-final words with any nonzero count carry four bytes
    add_n = (!in_item.last_item && nb != 3'd0) ? 3'd4 : nb;
    keep = (nb == 3'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - {nb, 3'b000}));
    if (in_item.last_item && nb != 3'd4)
      msg_w = (in_item.msg_word & keep) | (PAD_WORD >> {nb, 3'b000});
    else
      msg_w = in_item.msg_word;
    bits = {total_r, 3'b000};
    case (cmd.src)
      SRC_MSG:    push_w = msg_w;
      SRC_ZERO:   push_w = 32'h0;
      SRC_PAD:    push_w = PAD_WORD;
      SRC_LEN_HI: push_w = bits[63:32];
      default:    push_w = bits[31:0];
    endcase
    t4  = rnd_r[3:0];
    w15 = win_r[t4 + 4'd1];
    w2  = win_r[t4 + 4'd14];
    s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    w   = (rnd_r < 6'd16) ? win_r[t4] : win_r[t4] + s0 + win_r[t4 + 4'd9] + s1;
    t1  = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
        + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r] + w;
    t2  = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
        + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.push) win_r[fill_r] <= push_w;
    else if (cmd.round && rnd_r >= 6'd16) win_r[t4] <= w;
    if (cmd.load_vars) v_r <= h_r;
    else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      h_r     <= INIT_H;
      total_r <= '0;
      fill_r  <= '0;
      rnd_r   <= '0;
    end else begin
      if (cmd.add_bytes) total_r <= total_r + 61'(add_n);
      if (cmd.push) fill_r <= fill_r + 4'd1;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign status.fill      = fill_r;
  assign status.round_idx = rnd_r;
  assign digest_word      = h_r[emit_idx];
endmodule

### sv/sha256_ctrl.sv
// SHA-256 controller FSM: accepts items, sequences pushes, rounds, padding
// and digest output. Uses sha256_pkg.
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sha256_pkg::in_item_t in_item,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t     cmd,
  output logic [2:0]           emit_idx
);
  import sha256_pkg::*;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;     // message ended, padding in progress
  logic       pad80_r, pad80_nxt; // full last word: 0x80 word still owed
  logic [2:0] idx_r, idx_nxt;
  logic       acc, use_word;
  src_t       prev_src_r;         // source of the most recent pushed word

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      pad80_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      pad80_r <= pad80_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    pad80_nxt = pad80_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.src   = SRC_MSG;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    acc       = 1'b0;
    use_word  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        acc = in_valid;
        if (acc) begin
          cmd.add_bytes = 1'b1;
          use_word = in_item.byte_count != 3'd0 || in_item.last_item;
          cmd.push = use_word;
          if (in_item.last_item) begin
            fin_nxt   = 1'b1;
            pad80_nxt = in_item.byte_count >= 3'd4;
          end
          if (use_word && status.fill == 4'd15) begin
            cmd.load_vars = 1'b1;
            state_nxt = ST_ROUND;
          end else if (in_item.last_item) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (pad80_r) begin
          cmd.src = SRC_PAD;
          pad80_nxt = 1'b0;
        end else if (status.fill == 4'd15 && prev_src_r == SRC_LEN_HI) cmd.src = SRC_LEN_LO;
        else if (status.fill == 4'd14) cmd.src = SRC_LEN_HI;
        else cmd.src = SRC_ZERO;
        if (status.fill == 4'd15) begin
          cmd.load_vars = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_idx == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        // length words land at 14/15; fill is 0 here
        if (!fin_r) state_nxt = ST_IDLE;
        else if (pad80_r || status.fill != 4'd0 || prev_src_r != SRC_LEN_LO)
          state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reinit = 1'b1;
            fin_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prev_src_r <= SRC_MSG;
    else if (cmd.push) prev_src_r <= cmd.src;
  end

  assign emit_idx = idx_r;
endmodule

### sv/sha256_message_digest.sv
// SHA-256 streaming hash, top level. Ties controller and datapath together.
// Uses sha256_pkg, sha256_ctrl, sha256_dp.
`timescale 1ns / 1ps
// Message words enter big-endian on in_*; only the word with last_item may
// carry fewer than four bytes. Every 16th word starts a 64-round compression
// (one round per cycle in a single round unit) followed by a fold, during
// which in_ready is low. After the last word the padding and length words
// are written one per cycle, which may add a second compression, then the
// eight digest words leave on out_*, word 0 first, and the block returns
// to the initial hash values.
module sha256_message_digest (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [2:0] emit_idx;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_item(in_data), .in_ready,
    .out_valid, .out_ready, .status, .cmd, .emit_idx);

  sha256_dp u_dp (
    .clk, .rst_n, .cmd, .in_item(in_data), .emit_idx, .status, .digest_word);

  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = emit_idx;
  assign out_data.last_word   = emit_idx == 3'd7;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during output");
  a_round_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> !in_ready) else $error("input taken during rounds");
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && emit_idx != 3'd7) |=> out_valid)
    else $error("digest output broken off");
`endif
endmodule
